// File: design/smss_pkg.sv
// Shared types and constants for the sorted matrix staircase search block.
`timescale 1ns / 1ps
`default_nettype none

package smss_pkg;

  localparam int DEF_MAX_ROWS      = 16;
  localparam int DEF_MAX_COLS      = 16;
  localparam int DEF_ELEMENT_WIDTH = 32;

  localparam int IDX_W   = 4;
  localparam int FIELD_W = 32;
  localparam int CFG_W   = 5;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ROWS_RESET = 5'd16;
  localparam logic [CFG_W-1:0] COLS_RESET = 5'd16;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } smss_res_t;

endpackage

`default_nettype wire

// File: design/smss_mem.sv
// Matrix element memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module smss_mem #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1 << AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/smss_walk.sv
// Staircase walk sequencer: one memory read and one compare per step.
`timescale 1ns / 1ps
`default_nettype none

module smss_walk
  import smss_pkg::*;
#(
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int MAX_COLS      = DEF_MAX_COLS,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  wire logic [$clog2(MAX_COLS+1)-1:0] cols,
  input  wire logic [ELEMENT_WIDTH-1:0] key_in,
  input  wire logic [ELEMENT_WIDTH-1:0] rdata,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
                + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) - 1:0] raddr,
  output logic idle,
  output logic res_valid,
  output smss_res_t res,
  input  wire logic res_take
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [RCW-1:0] x, x_next;
  logic [CCW-1:0] ycnt, ycnt_next;
  logic [ELEMENT_WIDTH-1:0] key, key_next;
  smss_res_t res_next;
  logic [CCW-1:0] ycol, ycol_next;
  logic [RCW+IDX_W-1:0] row_wide;
  logic [CCW+IDX_W-1:0] col_wide;
  logic gt, lt;

  assign ycol      = ycnt - 1'b1;
  assign ycol_next = ycnt_next - 1'b1;
  assign row_wide  = {{IDX_W{1'b0}}, x};
  assign col_wide  = {{IDX_W{1'b0}}, ycol};
  assign gt = $signed(rdata) > $signed(key);
  assign lt = $signed(rdata) < $signed(key);

  always_comb begin
    state_next = state;
    x_next     = x;
    ycnt_next  = ycnt;
    key_next   = key;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (start) begin
          key_next  = key_in;
          x_next    = '0;
          ycnt_next = cols;
          if (rows == '0 || cols == '0) begin
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (gt) begin
          ycnt_next = ycnt - 1'b1;
          if (ycnt_next == '0) begin
            res_next   = '0;
            state_next = S_DONE;
          end
        end else if (lt) begin
          x_next = x + 1'b1;
          if (x_next == rows) begin
            res_next   = '0;
            state_next = S_DONE;
          end
        end else begin
          res_next.found = 1'b1;
          res_next.row   = row_wide[IDX_W-1:0];
          res_next.col   = col_wide[IDX_W-1:0];
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign raddr     = {x_next[RW-1:0], ycol_next[CW-1:0]};
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    x    <= x_next;
    ycnt <= ycnt_next;
    key  <= key_next;
    res  <= res_next;
  end

  a_walk_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (x < rows && ycnt != '0))
    else $error("walk position outside the search region");

  a_walk_progress: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (state != S_WALK || x != $past(x) || ycnt != $past(ycnt)))
    else $error("walk step made no progress");

  a_walk_col_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (state != S_WALK || ycnt <= $past(ycnt)))
    else $error("walk moved right");

  a_miss_zero_coords: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res.found) |-> (res.row == '0 && res.col == '0))
    else $error("not found result with nonzero coordinates");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("search started while busy");

endmodule

`default_nettype wire

// File: design/sorted_matrix_staircase_search.sv
// Top level of the sorted matrix staircase search block.
//
//   Channel   Direction  Signals                          Contents
//   s_*       in         s_tvalid s_tready s_tdata s_tuser  load or search request
//   m_*       out        m_tvalid m_tready m_tdata m_tuser  search result
//   cfg_*     in         cfg_we cfg_index cfg_data          region registers
//
// A load is written to the matrix memory when it is accepted. A search is
// accepted when idle, reads the matrix once per walk step through its single
// read port (at most rows plus columns minus one), then hands the result over.
// Reset is synchronous; it sets the region to 16 by 16 and leaves the matrix
// contents undefined. A result that waits on m_tready holds the walk, and no
// new request is taken until it has moved to the output register.
`timescale 1ns / 1ps
`default_nettype none

module sorted_matrix_staircase_search
  import smss_pkg::*;
#(
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int MAX_COLS      = DEF_MAX_COLS,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // load_row[3:0], load_col[7:4], element_value[39:8], search_key[71:40]
  input  wire logic [71:0]      s_tdata,
  // func[0]
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // found_row[3:0], found_col[7:4]
  output logic [7:0]            m_tdata,
  // found[0]
  output logic                  m_tuser,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;

  logic [IDX_W-1:0] load_row;
  logic [IDX_W-1:0] load_col;
  logic [FIELD_W-1:0] element_value;
  logic [FIELD_W-1:0] search_key;
  logic [FIELD_W+ELEMENT_WIDTH-1:0] elem_wide;
  logic [FIELD_W+ELEMENT_WIDTH-1:0] key_wide;

  logic accept;
  logic load_ok;
  logic start;
  logic walk_idle;
  logic res_valid;
  logic res_take;
  smss_res_t res;
  logic [RW+CW-1:0] raddr;
  logic [ELEMENT_WIDTH-1:0] rdata;

  assign load_row      = s_tdata[3:0];
  assign load_col      = s_tdata[7:4];
  assign element_value = s_tdata[39:8];
  assign search_key    = s_tdata[71:40];

  assign elem_wide = {{ELEMENT_WIDTH{1'b0}}, element_value};
  assign key_wide  = {{ELEMENT_WIDTH{1'b0}}, search_key};

  assign rows_eff = (32'(rows_in_use) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_in_use);
  assign cols_eff = (32'(cols_in_use) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_in_use);

  assign s_tready = walk_idle;
  assign accept   = s_tvalid && s_tready;
  assign load_ok  = accept && (s_tuser == FUNC_LOAD)
                    && (32'(load_row) < MAX_ROWS) && (32'(load_col) < MAX_COLS);
  assign start    = accept && (s_tuser == FUNC_SEARCH);
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  smss_mem #(
    .AW(RW + CW),
    .DW(ELEMENT_WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (load_ok),
    .waddr({RW'(load_row), CW'(load_col)}),
    .wdata(elem_wide[ELEMENT_WIDTH-1:0]),
    .raddr(raddr),
    .rdata(rdata)
  );

  smss_walk #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .key_in   (key_wide[ELEMENT_WIDTH-1:0]),
    .rdata    (rdata),
    .raddr    (raddr),
    .idle     (walk_idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tuser <= res.found;
      m_tdata <= {res.col, res.row};
    end
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for the sorted matrix staircase search block with a predictor and randomized phases.
`timescale 1ns / 1ps

module tb;
  import smss_pkg::*;

  typedef struct packed {
    logic        func;
    logic [3:0]  lrow;
    logic [3:0]  lcol;
    logic [31:0] elem;
    logic [31:0] key;
  } smx_req_t;

  localparam logic [31:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [31:0] ELEM_MAX = 32'h7fff_ffff;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [71:0]      s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             m_tuser;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  sorted_matrix_staircase_search DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  smx_req_t           req_q[$];
  smss_res_t          result_q[$];
  logic signed [31:0] tableau [0:255];
  logic signed [31:0] gen_mat [0:255];
  logic [CFG_W-1:0]   rows_cfg = ROWS_RESET;
  logic [CFG_W-1:0]   cols_cfg = COLS_RESET;
  bit                 in_taken = 1'b0;
  bit                 calm = 1'b0;
  int                 err_cnt = 0;
  int                 res_seen = 0;
  int                 item_total = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  int                 holds_done = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int clamp16(input logic [CFG_W-1:0] v);
    return (v > 5'd16) ? 16 : int'(v);
  endfunction

  function automatic smss_res_t staircase_walk(input logic signed [31:0] key);
    int                 nr;
    int                 nc;
    int                 x;
    int                 y;
    bit                 hit;
    logic signed [31:0] e;
    smss_res_t          res;
    nr = clamp16(rows_cfg);
    nc = clamp16(cols_cfg);
    res = '0;
    hit = 1'b0;
    x = 0;
    y = nc - 1;
    while (!hit && x < nr && y >= 0) begin
      e = tableau[{x[3:0], y[3:0]}];
      if (e > key) begin
        y--;
      end else if (e < key) begin
        x++;
      end else begin
        hit = 1'b1;
        res.found = 1'b1;
        res.row = x[3:0];
        res.col = y[3:0];
      end
    end
    return res;
  endfunction

  // Input side: the offer stays put until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (req_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 6) - 1;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser <= req_q[0].func;
        s_tdata <= {req_q[0].key, req_q[0].elem, req_q[0].lcol, req_q[0].lrow};
      end
    end
  end

  // Output side: random stalls plus two long hold-offs.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_done < 2 && res_seen >= (holds_done == 0 ? 25 : 150)) begin
      holds_done++;
      hold_left = 300;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    smx_req_t  r;
    smss_res_t got;
    smss_res_t exp_res;
    in_taken = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      in_taken = 1'b1;
      r = req_q.pop_front();
      if (r.func == FUNC_LOAD) begin
        tableau[{r.lrow, r.lcol}] = r.elem;
      end else begin
        result_q.push_back(staircase_walk(r.key));
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      res_seen++;
      got = {m_tuser, m_tdata[3:0], m_tdata[7:4]};
      if (result_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result found=%b row=%0d col=%0d",
                 $time, got.found, got.row, got.col);
      end else begin
        exp_res = result_q.pop_front();
        if (got.found !== exp_res.found || got.row !== exp_res.row ||
            got.col !== exp_res.col) begin
          err_cnt++;
          $display("%0t: mismatch expected found=%b row=%0d col=%0d, got found=%b row=%0d col=%0d",
                   $time, exp_res.found, exp_res.row, exp_res.col,
                   got.found, got.row, got.col);
        end
      end
    end
  end

  task automatic push_load(input int row, input int col, input logic [31:0] v);
    smx_req_t r;
    r.func = FUNC_LOAD;
    r.lrow = row[3:0];
    r.lcol = col[3:0];
    r.elem = v;
    r.key = $urandom;
    gen_mat[{r.lrow, r.lcol}] = v;
    req_q.push_back(r);
    item_total++;
  endtask

  task automatic push_search(input logic [31:0] k);
    smx_req_t r;
    r.func = FUNC_SEARCH;
    r.lrow = 4'($urandom);
    r.lcol = 4'($urandom);
    r.elem = $urandom;
    r.key = k;
    req_q.push_back(r);
    item_total++;
  endtask

  task automatic wait_idle(input int tail);
    while (req_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_region(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROWS) rows_cfg = val;
    else cols_cfg = val;
  endtask

  task automatic set_region(input int nr, input int nc);
    wait_idle(8);
    write_region(REG_ROWS, nr[CFG_W-1:0]);
    write_region(REG_COLS, nc[CFG_W-1:0]);
  endtask

  // Each element is at least its upper and left neighbors, so rows and columns never decrease.
  task automatic fill_sorted(input int er, input int ec, input longint base, input int step);
    longint up;
    longint left;
    longint v;
    for (int r = 0; r < er; r++) begin
      for (int c = 0; c < ec; c++) begin
        up = (r > 0) ? longint'(gen_mat[{r[3:0] - 4'd1, c[3:0]}]) : base;
        left = (c > 0) ? longint'(gen_mat[{r[3:0], c[3:0] - 4'd1}]) : base;
        v = ((up > left) ? up : left) + longint'($urandom_range(0, step));
        if (v > longint'($signed(ELEM_MAX))) v = longint'($signed(ELEM_MAX));
        push_load(r, c, v[31:0]);
      end
    end
  endtask

  function automatic logic [31:0] pick_key(input int er, input int ec);
    logic [31:0] e;
    int          sel;
    if (er == 0 || ec == 0) return $urandom;
    e = gen_mat[{4'($urandom_range(0, er - 1)), 4'($urandom_range(0, ec - 1))}];
    sel = $urandom_range(0, 9);
    if (sel <= 5) return e;
    if (sel == 6) return e + 32'd1;
    if (sel == 7) return e - 32'd1;
    if (sel == 8) return $urandom;
    return $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
  endfunction

  task automatic run_phase(input int nr, input int nc, input int nsearch, input bit refill);
    int er;
    int ec;
    set_region(nr, nc);
    er = clamp16(nr[CFG_W-1:0]);
    ec = clamp16(nc[CFG_W-1:0]);
    if (refill && er > 0 && ec > 0) begin
      fill_sorted(er, ec, longint'($signed($urandom)) >>> 1, 1 << $urandom_range(0, 26));
    end
    for (int i = 0; i < nsearch; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        push_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end else begin
        push_search(pick_key(er, ec));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    int nr;
    int nc;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two by two corner region holding both extremes, then searches hitting every cell.
    set_region(2, 2);
    push_load(15, 15, ELEM_MAX);
    push_load(0, 0, ELEM_MIN);
    push_load(0, 1, 32'd0);
    push_load(1, 0, 32'hffff_ffff);
    push_load(1, 1, ELEM_MAX);
    push_search(ELEM_MIN);
    push_search(ELEM_MAX);
    push_search(32'd0);
    push_search(32'hffff_ffff);
    push_search(32'd5);
    push_search(ELEM_MIN + 32'd1);
    // Empty regions read nothing.
    set_region(0, 2);
    push_search(32'd0);
    set_region(2, 0);
    push_search(ELEM_MIN);
    set_region(1, 1);
    push_search(ELEM_MIN);
    push_search(32'd0);

    // Oversized register values clamp to the full matrix, which gets written completely.
    set_region(31, 20);
    fill_sorted(16, 16, longint'($signed(ELEM_MIN)) + longint'($urandom_range(0, 100)), 1 << 26);
    for (int i = 0; i < 40; i++) push_search(pick_key(16, 16));

    while (item_total < 820) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        if ($urandom_range(0, 1)) begin
          nr = 0;
          nc = $urandom_range(0, 31);
        end else begin
          nr = $urandom_range(1, 31);
          nc = 0;
        end
      end else if (k == 1) begin
        nr = $urandom_range(16, 31);
        nc = $urandom_range(16, 31);
      end else if (k == 2) begin
        nr = 1;
        nc = $urandom_range(1, 16);
      end else if (k == 3) begin
        nr = $urandom_range(1, 16);
        nc = 1;
      end else begin
        nr = $urandom_range(1, 6);
        nc = $urandom_range(1, 6);
      end
      run_phase(nr, nc, $urandom_range(10, 30), $urandom_range(0, 3) != 0);
    end

    wait_idle(8);
    calm = 1'b1;
    run_phase($urandom_range(3, 8), $urandom_range(3, 8), 50, 1'b1);

    wait_idle(40);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
